>>> rtl/core/gtpf_pkg.sv
// Shared types, constants and tag decode helpers for the packet framer.
`timescale 1ns / 1ps

package gtpf_pkg;

  localparam int NUM_PATHS  = 3;
  localparam int PATH_W     = 2;
  localparam int PATH_IDX_W = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
  localparam int QWORD_W    = 64;
  localparam int REM_W      = 19;
  localparam int CNT_W      = 32;

  // Tag field layout
  localparam int LOOP_W          = 15;
  localparam int EOP_BIT         = 15;
  localparam int FMT_LSB         = 58;
  localparam int FMT_W           = 2;
  localparam int REGS_LSB        = 60;
  localparam int REGS_W          = 4;
  localparam int REGS_ZERO_MEANS = 16;
  localparam int PROD_W          = LOOP_W + REGS_W + 1;

  localparam logic [PATH_W-1:0] DMA_PATH = PATH_W'(2);

  typedef enum logic {
    ACT_QWORD      = 1'b0,
    ACT_CTRL_RESET = 1'b1
  } action_t;

  typedef enum logic [FMT_W-1:0] {
    FMT_PACKED    = 2'd0,
    FMT_REGLIST   = 2'd1,
    FMT_IMAGE     = 2'd2,
    FMT_IMAGE_ALT = 2'd3
  } fmt_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic             in_pkt;
    logic             eop;
    logic [CNT_W-1:0] pkts;
    logic [CNT_W-1:0] bad;
  } path_state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  // Payload length in quadwords announced by a tag
  function automatic logic [REM_W-1:0] tag_len(input logic [QWORD_W-1:0] w);
    logic [LOOP_W-1:0] loops;
    logic [REGS_W:0]   regs;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] half;
    fmt_t              fmt;
    logic [REM_W-1:0]  len;
    loops = w[LOOP_W-1:0];
    regs  = (w[REGS_LSB +: REGS_W] == '0) ? (REGS_W+1)'(REGS_ZERO_MEANS)
                                          : {1'b0, w[REGS_LSB +: REGS_W]};
    prod  = loops * regs;
    half  = (prod + PROD_W'(1)) >> 1;
    fmt   = fmt_t'(w[FMT_LSB +: FMT_W]);
    case (fmt)
      FMT_PACKED:  len = prod[REM_W-1:0];
      FMT_REGLIST: len = half[REM_W-1:0];
      default:     len = REM_W'(loops);
    endcase
    return len;
  endfunction

endpackage

>>> rtl/core/gif_tag_packet_framer.sv
// Packet framer top level: input register, per-path state and result register.
`timescale 1ns / 1ps

// Frames graphics-interface packets on NUM_PATHS submission paths, one quadword
// per item. An item is taken into an input register, then in the next stage the
// state of its path (payload countdown, packet open, end-of-packet pending and two
// saturating counters, all in flip-flops) is read, updated and the result is
// written to the output register. One item is accepted every cycle while the
// output is not held off, and the input register keeps taking one more item
// while a result waits. Items are handled in order, so an item always sees the
// state left by the one before it. A control reset item clears all path state
// and returns all zeros; a quadword on a path number at or beyond NUM_PATHS
// returns all zeros and leaves the path state unchanged.
module gif_tag_packet_framer
  import gtpf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [PATH_W-1:0]  path,
  input  logic [QWORD_W-1:0] qword_low,
  input  logic               last_in_submission,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               tag_started,
  output logic               packet_done,
  output logic [REM_W-1:0]   payload_left,
  output logic               ended_mid_tag,
  output logic               ended_mid_packet,
  output logic [CNT_W-1:0]   packet_count,
  output logic [CNT_W-1:0]   malformed_count
);

  logic               s1_valid;
  action_t            s1_action;
  logic [PATH_W-1:0]  s1_path;
  logic [QWORD_W-1:0] s1_qword;
  logic               s1_last;
  logic               s1_adv;

  path_state_t        st [NUM_PATHS];
  path_state_t        cur;
  path_state_t        cur_next;
  logic [PATH_IDX_W-1:0] idx;
  logic               path_ok;
  logic               is_tag;
  logic               eop_now;
  logic               open_now;
  logic               done;
  logic               check_end;
  logic               mid_tag;
  logic               mid_pkt;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action <= action_t'(action);
      s1_path   <= path;
      s1_qword  <= qword_low;
      s1_last   <= last_in_submission;
    end
  end

  assign path_ok = {1'b0, s1_path} < (PATH_W+1)'(NUM_PATHS);
  assign idx     = s1_path[PATH_IDX_W-1:0];

  always_comb begin
    cur       = path_ok ? st[idx] : '0;
    cur_next  = cur;
    is_tag    = (cur.rem == '0);
    // tag boundary: load a new countdown, else consume one payload quadword
    cur_next.rem = is_tag ? tag_len(s1_qword) : cur.rem - REM_W'(1);
    eop_now   = is_tag ? s1_qword[EOP_BIT] : cur.eop;
    open_now  = is_tag ? 1'b1 : cur.in_pkt;
    done      = (cur_next.rem == '0) && open_now && eop_now;
    cur_next.in_pkt = open_now && !done;
    cur_next.eop    = eop_now && !done;
    cur_next.pkts   = done ? sat_inc(cur.pkts) : cur.pkts;
    check_end = s1_last && (s1_path != DMA_PATH);
    mid_tag   = check_end && (cur_next.rem != '0);
    mid_pkt   = check_end && cur_next.in_pkt && (cur_next.rem == '0);
    cur_next.bad = mid_tag ? sat_inc(cur.bad) : cur.bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PATHS; i++) begin
        st[i] <= '0;
      end
    end else if (s1_adv) begin
      if (s1_action == ACT_CTRL_RESET) begin
        for (int i = 0; i < NUM_PATHS; i++) begin
          st[i] <= '0;
        end
      end else if (path_ok) begin
        st[idx] <= cur_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_action == ACT_CTRL_RESET || !path_ok) begin
        tag_started      <= 1'b0;
        packet_done      <= 1'b0;
        payload_left     <= '0;
        ended_mid_tag    <= 1'b0;
        ended_mid_packet <= 1'b0;
        packet_count     <= '0;
        malformed_count  <= '0;
      end else begin
        tag_started      <= is_tag;
        packet_done      <= done;
        payload_left     <= cur_next.rem;
        ended_mid_tag    <= mid_tag;
        ended_mid_packet <= mid_pkt;
        packet_count     <= cur_next.pkts;
        malformed_count  <= cur_next.bad;
      end
    end
  end

endmodule

>>> rtl/core/gtpf_checker.sv
// Port-level checks for the packet framer, bound to the top level.
`timescale 1ns / 1ps

module gtpf_checker
  import gtpf_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               tag_started,
  input logic               packet_done,
  input logic [REM_W-1:0]   payload_left,
  input logic               ended_mid_tag,
  input logic               ended_mid_packet,
  input logic [CNT_W-1:0]   packet_count,
  input logic [CNT_W-1:0]   malformed_count
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tag_started)
      && $stable(packet_done) && $stable(payload_left)
      && $stable(ended_mid_tag) && $stable(ended_mid_packet)
      && $stable(packet_count) && $stable(malformed_count))
    else $error("result changed while stalled");

  // input backs up only behind a held result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // an unfinished payload at submission end is malformed, never a boundary
  a_mid_tag: assert property (@(posedge clk) disable iff (rst)
    out_valid && ended_mid_tag |-> payload_left != '0 && !ended_mid_packet)
    else $error("mid-tag end with no payload outstanding");

  a_mid_pkt: assert property (@(posedge clk) disable iff (rst)
    out_valid && ended_mid_packet |-> payload_left == '0 && !packet_done)
    else $error("mid-packet end inconsistent");

  // a packet closes only with its payload exhausted
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_done |-> payload_left == '0 && packet_count != '0)
    else $error("packet done with payload left or zero count");

endmodule

bind gif_tag_packet_framer gtpf_checker u_gtpf_checker (.*);

>>> verif/gif_tag_packet_framer_tb.sv
// Self-checking testbench for the packet framer: framing predictor, random submissions, stalls.
`timescale 1ns / 1ps

module gif_tag_packet_framer_tb;
  import gtpf_pkg::*;

  typedef struct {
    logic             tag;
    logic             done;
    logic [REM_W-1:0] left;
    logic             mid_tag;
    logic             mid_pkt;
    logic [CNT_W-1:0] pkts;
    logic [CNT_W-1:0] bad;
  } framer_result_t;

  class packet_framer_scoreboard;
    bit [19:0]        remaining [NUM_PATHS];
    bit               open_pkt  [NUM_PATHS];
    bit               eop_due   [NUM_PATHS];
    bit [CNT_W-1:0]   pkt_cnt   [NUM_PATHS];
    bit [CNT_W-1:0]   bad_cnt   [NUM_PATHS];
    framer_result_t   pending_results[$];
    int               errors;

    function void clear_paths();
      for (int i = 0; i < NUM_PATHS; i++) begin
        remaining[i] = '0;
        open_pkt[i]  = 1'b0;
        eop_due[i]   = 1'b0;
        pkt_cnt[i]   = '0;
        bad_cnt[i]   = '0;
      end
    endfunction

    function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] v);
      return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function bit [19:0] payload_len(logic [QWORD_W-1:0] w);
      int unsigned loops;
      int unsigned regs;
      int unsigned prod;
      loops = w[LOOP_W-1:0];
      regs  = w[REGS_LSB +: REGS_W];
      if (regs == 0) regs = REGS_ZERO_MEANS;
      prod = loops * regs;
      case (fmt_t'(w[FMT_LSB +: FMT_W]))
        FMT_PACKED:  return 20'(prod);
        FMT_REGLIST: return 20'((prod + 1) / 2);
        default:     return 20'(loops);
      endcase
    endfunction

    // Works out the result of one accepted item and queues it
    function void predict_framing(action_t act, logic [PATH_W-1:0] p,
                                  logic [QWORD_W-1:0] w, logic last);
      framer_result_t r;
      int idx;
      r = '{default: '0};
      if (act == ACT_CTRL_RESET) begin
        clear_paths();
      end else if (p < NUM_PATHS) begin
        idx = p;
        if (remaining[idx] == 0) begin
          remaining[idx] = payload_len(w);
          eop_due[idx]   = w[EOP_BIT];
          open_pkt[idx]  = 1'b1;
          r.tag          = 1'b1;
        end else begin
          remaining[idx] = remaining[idx] - 20'd1;
        end
        if (remaining[idx] == 0 && open_pkt[idx] && eop_due[idx]) begin
          open_pkt[idx] = 1'b0;
          eop_due[idx]  = 1'b0;
          pkt_cnt[idx]  = bump(pkt_cnt[idx]);
          r.done        = 1'b1;
        end
        if (last && p != DMA_PATH) begin
          if (open_pkt[idx] && remaining[idx] == 0) r.mid_pkt = 1'b1;
          if (remaining[idx] > 0) begin
            bad_cnt[idx] = bump(bad_cnt[idx]);
            r.mid_tag    = 1'b1;
          end
        end
        r.left = remaining[idx][REM_W-1:0];
        r.pkts = pkt_cnt[idx];
        r.bad  = bad_cnt[idx];
      end
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 10)
        $display("%0t mismatch %s: expected %0h actual %0h", $realtime, what, want, got);
    endfunction

    function void cmp(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) flag(what, want, got);
    endfunction

    function void check_framing(framer_result_t got);
      framer_result_t want;
      if (pending_results.size() == 0) begin
        flag("result with nothing pending", 0, 0);
        return;
      end
      want = pending_results.pop_front();
      cmp("tag_started", want.tag, got.tag);
      cmp("packet_done", want.done, got.done);
      cmp("payload_left", want.left, got.left);
      cmp("ended_mid_tag", want.mid_tag, got.mid_tag);
      cmp("ended_mid_packet", want.mid_pkt, got.mid_pkt);
      cmp("packet_count", want.pkts, got.pkts);
      cmp("malformed_count", want.bad, got.bad);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               action;
  logic [PATH_W-1:0]  path;
  logic [QWORD_W-1:0] qword_low;
  logic               last_in_submission;
  logic               out_valid;
  logic               out_stall;
  logic               tag_started;
  logic               packet_done;
  logic [REM_W-1:0]   payload_left;
  logic               ended_mid_tag;
  logic               ended_mid_packet;
  logic [CNT_W-1:0]   packet_count;
  logic [CNT_W-1:0]   malformed_count;

  packet_framer_scoreboard sb = new();
  framer_result_t seen;
  int        idle_pct;
  int        stall_pct;
  int        n_sent;
  bit        hold_armed;
  int        hold_left;
  bit [19:0] gen_left [NUM_PATHS];

  gif_tag_packet_framer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .path(path), .qword_low(qword_low),
    .last_in_submission(last_in_submission),
    .out_valid(out_valid), .out_stall(out_stall),
    .tag_started(tag_started), .packet_done(packet_done),
    .payload_left(payload_left), .ended_mid_tag(ended_mid_tag),
    .ended_mid_packet(ended_mid_packet), .packet_count(packet_count),
    .malformed_count(malformed_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.predict_framing(action_t'(action), path, qword_low, last_in_submission);
    if (!rst && out_valid && !out_stall) begin
      seen.tag     = tag_started;
      seen.done    = packet_done;
      seen.left    = payload_left;
      seen.mid_tag = ended_mid_tag;
      seen.mid_pkt = ended_mid_packet;
      seen.pkts    = packet_count;
      seen.bad     = malformed_count;
      sb.check_framing(seen);
    end
  end

  // Receiver: random stalls, plus one long hold-off so the input side backs up
  always @(posedge clk) begin
    if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left  = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_item(action_t a, logic [PATH_W-1:0] p, logic [QWORD_W-1:0] w,
                           logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    action             <= a;
    path               <= p;
    qword_low          <= w;
    last_in_submission <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_reset();
    send_item(ACT_CTRL_RESET, PATH_W'($urandom_range(0, 3)), {$urandom, $urandom},
              1'($urandom_range(0, 1)));
    for (int i = 0; i < NUM_PATHS; i++) gen_left[i] = '0;
  endtask

  function automatic logic [QWORD_W-1:0] make_tag(int loops, bit eop, fmt_t fmt, int regs);
    logic [QWORD_W-1:0] t;
    t = {$urandom, $urandom};
    t[LOOP_W-1:0]           = LOOP_W'(loops);
    t[EOP_BIT]              = eop;
    t[FMT_LSB +: FMT_W]     = fmt;
    t[REGS_LSB +: REGS_W]   = REGS_W'(regs);
    return t;
  endfunction

  // One submission of whole tags on one path; sometimes cut short
  task automatic send_submission();
    logic [QWORD_W-1:0] words[$];
    logic [QWORD_W-1:0] t;
    int p;
    int ntags;
    int cut;
    int n;
    int loops;
    p = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, NUM_PATHS - 1);
    // finish a payload left open by an earlier cut submission
    if (p < NUM_PATHS)
      for (int k = 0; k < gen_left[p]; k++) words.insert(words.size(), {$urandom, $urandom});
    ntags = $urandom_range(1, 3);
    for (int i = 0; i < ntags; i++) begin
      loops = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      t = make_tag(loops, (i == ntags - 1) && ($urandom_range(0, 4) != 0),
                   fmt_t'($urandom_range(0, 3)), $urandom_range(0, 15));
      words.insert(words.size(), t);
      repeat (sb.payload_len(t)) words.insert(words.size(), {$urandom, $urandom});
    end
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, words.size() - 1) : 0;
    n = words.size() - cut;
    for (int i = 0; i < n; i++) begin
      send_item(ACT_QWORD, PATH_W'(p), words[i], i == n - 1);
      if (p < NUM_PATHS)
        gen_left[p] = (gen_left[p] == 0) ? sb.payload_len(words[i]) : gen_left[p] - 20'd1;
    end
  endtask

  task automatic run_random(int count);
    int stop;
    int pick;
    stop = n_sent + count;
    while (n_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 86) begin
        send_submission();
      end else if (pick < 95) begin
        // raw noise on any path, then clear everything
        repeat ($urandom_range(1, 3))
          send_item(ACT_QWORD, PATH_W'($urandom_range(0, 3)), {$urandom, $urandom},
                    1'($urandom_range(0, 1)));
        send_reset();
      end else begin
        send_reset();
      end
    end
  endtask

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    in_valid           = 1'b0;
    action             = ACT_QWORD;
    path               = '0;
    qword_low          = '0;
    last_in_submission = 1'b0;
    out_stall          = 1'b0;
    idle_pct           = 0;
    stall_pct          = 0;
    n_sent             = 0;
    hold_armed         = 1'b0;
    hold_left          = 0;
    for (int i = 0; i < NUM_PATHS; i++) gen_left[i] = '0;
    sb.clear_paths();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // largest tag, submission ends inside its payload twice, then cleared
    send_item(ACT_QWORD, 0, make_tag(15'h7FFF, 1, FMT_PACKED, 0), 1'b1);
    send_item(ACT_QWORD, 0, {$urandom, $urandom}, 1'b1);
    send_item(ACT_CTRL_RESET, 0, '1, 1'b1);
    // register list, rounded-up half length, clean end
    send_item(ACT_QWORD, 1, make_tag(3, 1, FMT_REGLIST, 3), 1'b0);
    for (int i = 0; i < 5; i++) send_item(ACT_QWORD, 1, '0, i == 4);
    // dma may end mid payload without flags
    send_item(ACT_QWORD, 2, make_tag(2, 1, FMT_IMAGE, 7), 1'b0);
    send_item(ACT_QWORD, 2, '1, 1'b1);
    // zero-length tags without end-of-packet keep the packet open
    send_item(ACT_QWORD, 0, make_tag(0, 0, FMT_PACKED, 0), 1'b0);
    send_item(ACT_QWORD, 0, make_tag(0, 0, FMT_REGLIST, 9), 1'b1);
    send_item(ACT_QWORD, 0, make_tag(1, 1, FMT_IMAGE_ALT, 15), 1'b0);
    send_item(ACT_QWORD, 0, '1, 1'b1);
    send_item(ACT_QWORD, 3, '1, 1'b1);
    send_item(ACT_QWORD, 1, make_tag(1, 0, FMT_PACKED, 1), 1'b0);
    send_item(ACT_QWORD, 1, '0, 1'b1);
    send_item(ACT_QWORD, 0, make_tag(0, 1, FMT_PACKED, 4), 1'b1);
    send_item(ACT_CTRL_RESET, 3, '1, 1'b0);

    hold_armed = 1'b1;
    run_random(460);
    idle_pct = 86;
    run_random(460);
    idle_pct  = 0;
    stall_pct = 86;
    run_random(460);
    idle_pct  = 19;
    stall_pct = 19;
    run_random(460);
    in_valid <= 1'b0;

    // let the monitor note the last accepted item before draining
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.errors += sb.pending_results.size();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
